[hdl/waypoint_route_follower_core_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the waypoint route follower
// Shared clocked assertion forms.
// ----------------------------------------------------------------------------
`ifndef WAYPOINT_ROUTE_FOLLOWER_CORE_MACROS_SVH
`define WAYPOINT_ROUTE_FOLLOWER_CORE_MACROS_SVH

// property that must hold on every edge outside reset
`define WRF_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// antecedent implies consequent on the next edge
`define WRF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/wrf_pkg.sv]
// ----------------------------------------------------------------------------
// wrf_pkg
// Types and constants of the waypoint route follower.
// ----------------------------------------------------------------------------
package wrf_pkg;

    localparam int unsigned ROUTE_DEPTH_DEF = 64;
    localparam logic [31:0] SPEED_RESET     = 32'h0001_0000;

    typedef enum logic [1:0] {
        OP_TICK = 2'd0,
        OP_LOAD = 2'd1,
        OP_SETP = 2'd2,
        OP_NONE = 2'd3
    } t_op;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_RD1,      // memory read of target
        ST_RD1W,
        ST_STEP,     // step multiply
        ST_DIST,     // setup distance
        ST_SQ,       // squares, one axis per cycle
        ST_SQRT,     // isqrt iterations
        ST_DEC1,     // compare dist/step
        ST_RD2,
        ST_RD2W,
        ST_DEC2,
        ST_DIV,      // fraction bits
        ST_LERP,     // one axis per cycle
        ST_OUT
    } t_state;

    // handshake to the arithmetic unit
    typedef struct packed {
        logic sq_start;
        logic div_start;
    } t_au_ctl;

endpackage

[hdl/wrf_sqrt_div.sv]
// ----------------------------------------------------------------------------
// wrf_sqrt_div
// Shared iterative unit: bit-pair square root of a 66-bit value and a
// 32-bit restoring fraction divide, one step per cycle.
// ----------------------------------------------------------------------------
module wrf_sqrt_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  wrf_pkg::t_au_ctl  i_ctl,
    input  logic [65:0]       i_rad,
    input  logic [65:0]       i_num,
    input  logic [65:0]       i_den,
    output logic              o_busy,
    output logic [32:0]       o_root,
    output logic [31:0]       o_frac
);
    logic [67:0] r_v;
    logic [67:0] r_res;
    logic [67:0] r_bit;
    logic [66:0] r_rem;
    logic [65:0] r_den;
    logic [31:0] r_t;
    logic [5:0]  r_cnt;
    logic        r_sq;
    logic        r_busy;
    logic [67:0] w_sum;
    logic [66:0] w_sh;

    assign w_sum = r_res + r_bit;
    assign w_sh  = {r_rem[65:0], 1'b0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_sq   <= 1'b0;
        end else if (i_ctl.sq_start) begin
            r_busy <= 1'b1;
            r_sq   <= 1'b1;
            r_cnt  <= 6'd34;
            r_v    <= {2'b00, i_rad};
            r_res  <= '0;
            r_bit  <= 68'd1 << 66;
        end else if (i_ctl.div_start) begin
            r_busy <= 1'b1;
            r_sq   <= 1'b0;
            r_cnt  <= 6'd32;
            r_rem  <= {1'b0, i_num};
            r_den  <= i_den;
            r_t    <= '0;
        end else if (r_busy) begin
            if (r_sq) begin
                if (r_v >= w_sum) begin
                    r_v   <= r_v - w_sum;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
            end else begin
                if (w_sh >= {1'b0, r_den}) begin
                    r_rem <= w_sh - {1'b0, r_den};
                    r_t   <= {r_t[30:0], 1'b1};
                end else begin
                    r_rem <= w_sh;
                    r_t   <= {r_t[30:0], 1'b0};
                end
            end
            r_cnt <= r_cnt - 6'd1;
            if (r_cnt == 6'd1) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_root = r_res[32:0];
    assign o_frac = r_t;
endmodule

[hdl/waypoint_route_follower_core.sv]
// ----------------------------------------------------------------------------
// waypoint_route_follower_core
// Q16.16 3-D waypoint follower: loads a route, sets the position and moves
// the position along the route by speed * delta_time on each tick.
// ----------------------------------------------------------------------------
// Loads, position sets and unknown opcodes pass through ST_RD1 and ST_OUT
// before their result beat. A tick runs a small sequencer around one shared
// unit: the route memory is read with a registered port, the three squared
// axis offsets are summed one multiply per cycle, a 34-step square root
// gives the segment length, a 32-step restoring divide gives the fraction,
// and one multiply per axis interpolates. A tick that passes a waypoint
// works out two lengths and at most one fraction. The square root and the
// divide take the largest share of a tick. i_stall is honored on the result
// beat; o_stall is high whenever an item is in work or a result waits, so
// the next input beat is taken at the earliest in the cycle after the result
// beat leaves. The route memory has no reset: only entries below the fill
// count are read.
module waypoint_route_follower_core #(
    parameter int unsigned ROUTE_DEPTH = wrf_pkg::ROUTE_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_opcode,
    input  logic signed [31:0] i_coord_x,
    input  logic signed [31:0] i_coord_y,
    input  logic signed [31:0] i_coord_z,
    input  logic               i_first_point,
    input  logic               i_final_point,
    input  logic [15:0]        i_delta_time,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_pos_x,
    output logic signed [31:0] o_pos_y,
    output logic signed [31:0] o_pos_z,
    output logic               o_arrived,
    output logic               o_active,
    output logic               o_route_overflow
);
`include "waypoint_route_follower_core_macros.svh"

    localparam int unsigned AW = (ROUTE_DEPTH > 1) ? $clog2(ROUTE_DEPTH) : 1;
    localparam int unsigned CW = $clog2(ROUTE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(ROUTE_DEPTH);

    logic [95:0] r_mem [ROUTE_DEPTH];
    logic [95:0] r_rd;

    logic [31:0]   r_speed;
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_slot;
    logic          r_moving;
    logic signed [31:0] r_cur [3];

    wrf_pkg::t_state r_state, n_state;
    logic [1:0]  r_op;
    logic [95:0] r_in;
    logic        r_first, r_final;
    logic [15:0] r_dt;
    logic        r_seg2;        // working on the next segment
    logic [32:0] r_step;        // step or leftover
    logic signed [31:0] r_base [3];  // lerp start
    logic signed [31:0] r_tgt  [3];  // lerp end
    logic [32:0] r_mag [3];
    logic        r_neg [3];
    logic [1:0]  r_shift;
    logic [1:0]  r_ax;
    logic [65:0] r_acc;
    logic [32:0] r_dist;
    logic        r_arr, r_ovf, r_ovalid;
    logic        r_rd_en;
    logic [AW-1:0] r_rd_addr;

    wrf_pkg::t_au_ctl w_ctl;
    logic        w_busy;
    logic [32:0] w_root;
    logic [31:0] w_frac;

    // shared multiplier operands (33 x 33)
    logic [32:0] w_ma, w_mb;
    logic [65:0] w_prod;
    assign w_prod = w_ma * w_mb;

    wrf_sqrt_div u_au (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (w_ctl),
        .i_rad  (r_acc),
        .i_num  ({r_step, 33'd0} >> 33),
        .i_den  ({33'd0, r_dist}),
        .o_busy (w_busy),
        .o_root (w_root),
        .o_frac (w_frac)
    );

    assign o_stall = (r_state != wrf_pkg::ST_IDLE) || r_ovalid;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            wrf_pkg::ST_IDLE:
                if (i_valid && !r_ovalid) n_state = wrf_pkg::ST_RD1;
            wrf_pkg::ST_RD1:
                if (r_op == wrf_pkg::OP_TICK && r_moving && r_slot < r_count)
                    n_state = wrf_pkg::ST_RD1W;
                else
                    n_state = wrf_pkg::ST_OUT;
            wrf_pkg::ST_RD1W: n_state = wrf_pkg::ST_STEP;
            wrf_pkg::ST_STEP: n_state = wrf_pkg::ST_DIST;
            wrf_pkg::ST_DIST: n_state = wrf_pkg::ST_SQ;
            wrf_pkg::ST_SQ:
                if (r_ax == 2'd2) n_state = wrf_pkg::ST_SQRT;
            wrf_pkg::ST_SQRT:
                if (!w_busy && !w_ctl.sq_start)
                    n_state = r_seg2 ? wrf_pkg::ST_DEC2 : wrf_pkg::ST_DEC1;
            wrf_pkg::ST_DEC1:
                if (r_dist > r_step) n_state = wrf_pkg::ST_DIV;
                else if (r_slot + 1'b1 >= r_count) n_state = wrf_pkg::ST_OUT;
                else n_state = wrf_pkg::ST_RD2;
            wrf_pkg::ST_RD2:  n_state = wrf_pkg::ST_RD2W;
            wrf_pkg::ST_RD2W: n_state = wrf_pkg::ST_DIST;
            wrf_pkg::ST_DEC2:
                if (r_dist == '0 || r_step >= r_dist) n_state = wrf_pkg::ST_OUT;
                else n_state = wrf_pkg::ST_DIV;
            wrf_pkg::ST_DIV:
                if (!w_busy && !w_ctl.div_start) n_state = wrf_pkg::ST_LERP;
            wrf_pkg::ST_LERP:
                if (r_ax == 2'd2) n_state = wrf_pkg::ST_OUT;
            wrf_pkg::ST_OUT:
                if (!r_ovalid) n_state = wrf_pkg::ST_IDLE;
            default: n_state = wrf_pkg::ST_IDLE;
        endcase
    end

    // unit controls and multiplier operands
    logic r_go;
    logic [1:0] w_shift;
    always_comb begin
        w_ctl.sq_start  = 1'b0;
        w_ctl.div_start = 1'b0;
        w_ma = '0;
        w_mb = '0;
        case (r_state)
            wrf_pkg::ST_SQRT: w_ctl.sq_start  = r_go;
            wrf_pkg::ST_DIV:  w_ctl.div_start = r_go;
            wrf_pkg::ST_STEP: begin
                w_ma = {17'd0, r_dt};
                w_mb = {1'b0, r_speed};
            end
            wrf_pkg::ST_SQ: begin
                w_ma = r_mag[r_ax] >> w_shift;
                w_mb = r_mag[r_ax] >> w_shift;
            end
            wrf_pkg::ST_LERP: begin
                w_ma = r_mag[r_ax];
                w_mb = {1'b0, w_frac};
            end
            default: ;
        endcase
    end

    logic [32:0] w_d [3];
    logic [32:0] w_off;
    logic [32:0] w_or;
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_d[i] = 33'({r_tgt[i][31], r_tgt[i]} - {r_base[i][31], r_base[i]});
        end
        w_or  = r_mag[0] | r_mag[1] | r_mag[2];
        w_off = 33'(w_prod >> 32);
    end

    // shift so every magnitude fits below 2^31
    assign w_shift = w_or[32] ? 2'd2 : (w_or[31] ? 2'd1 : 2'd0);

    always_ff @(posedge i_clk) begin
        if (r_rd_en) r_rd <= r_mem[r_rd_addr];
        if (r_state == wrf_pkg::ST_RD1 && r_op == wrf_pkg::OP_LOAD) begin
            if (!(r_first ? 1'b0 : (r_count >= DEPTH_C)))
                r_mem[r_first ? AW'(0) : r_count[AW-1:0]] <= r_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= wrf_pkg::ST_IDLE;
            r_speed  <= wrf_pkg::SPEED_RESET;
            r_count  <= '0;
            r_slot   <= '0;
            r_moving <= 1'b0;
            r_cur[0] <= '0;
            r_cur[1] <= '0;
            r_cur[2] <= '0;
            r_ovalid <= 1'b0;
            r_rd_en  <= 1'b0;
            r_go     <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rd_en <= 1'b0;
            r_go    <= 1'b0;
            if (i_cfg_we) r_speed <= i_cfg_data;
            if (r_ovalid && !i_stall) r_ovalid <= 1'b0;
            case (r_state)
                wrf_pkg::ST_IDLE: if (i_valid && !r_ovalid) begin
                    r_op    <= i_opcode;
                    r_in    <= {i_coord_z, i_coord_y, i_coord_x};
                    r_first <= i_first_point;
                    r_final <= i_final_point;
                    r_dt    <= i_delta_time;
                    r_arr   <= 1'b0;
                    r_ovf   <= 1'b0;
                    r_seg2  <= 1'b0;
                end
                wrf_pkg::ST_RD1: begin
                    case (r_op)
                        wrf_pkg::OP_TICK: begin
                            if (!(r_moving && r_slot < r_count)) r_moving <= 1'b0;
                            r_rd_en   <= 1'b1;
                            r_rd_addr <= r_slot[AW-1:0];
                        end
                        wrf_pkg::OP_LOAD: begin
                            if (r_first) begin
                                r_count  <= CW'(1);
                                r_slot   <= '0;
                                r_moving <= r_final;
                            end else if (r_count >= DEPTH_C) begin
                                r_ovf <= 1'b1;
                                if (r_final) begin
                                    r_moving <= 1'b1;
                                    r_slot   <= '0;
                                end
                            end else begin
                                r_count <= r_count + 1'b1;
                                if (r_final) begin
                                    r_moving <= 1'b1;
                                    r_slot   <= '0;
                                end
                            end
                        end
                        wrf_pkg::OP_SETP: begin
                            r_cur[0] <= r_in[31:0];
                            r_cur[1] <= r_in[63:32];
                            r_cur[2] <= r_in[95:64];
                        end
                        default: ;
                    endcase
                end
                wrf_pkg::ST_STEP: begin
                    r_step  <= 33'(w_prod >> 16);
                    r_base  <= r_cur;
                    r_tgt[0] <= r_rd[31:0];
                    r_tgt[1] <= r_rd[63:32];
                    r_tgt[2] <= r_rd[95:64];
                end
                wrf_pkg::ST_DIST: begin
                    for (int i = 0; i < 3; i++) begin
                        r_neg[i] <= w_d[i][32];
                        r_mag[i] <= w_d[i][32] ? 33'(-w_d[i]) : w_d[i];
                    end
                    r_ax  <= '0;
                    r_acc <= '0;
                end
                wrf_pkg::ST_SQ: begin
                    if (r_ax == 2'd0) begin
                        r_shift <= w_shift;
                        r_go    <= 1'b0;
                    end
                    r_acc <= r_acc + w_prod;
                    r_ax  <= r_ax + 2'd1;
                    if (r_ax == 2'd2) r_go <= 1'b1;
                end
                wrf_pkg::ST_SQRT: begin
                    if (!w_busy && !w_ctl.sq_start)
                        r_dist <= 33'(w_root << r_shift);
                end
                wrf_pkg::ST_DEC1: begin
                    if (r_dist > r_step) begin
                        r_go <= 1'b1;
                    end else begin
                        r_cur[0] <= r_tgt[0];
                        r_cur[1] <= r_tgt[1];
                        r_cur[2] <= r_tgt[2];
                        r_slot   <= r_slot + 1'b1;
                        r_step   <= r_step - r_dist;
                        if (r_slot + 1'b1 >= r_count) begin
                            r_moving <= 1'b0;
                            r_arr    <= 1'b1;
                        end else begin
                            r_rd_en   <= 1'b1;
                            r_rd_addr <= AW'(r_slot + 1'b1);
                        end
                    end
                end
                wrf_pkg::ST_RD2W: begin
                    r_seg2  <= 1'b1;
                    r_base  <= r_tgt;
                    r_tgt[0] <= r_rd[31:0];
                    r_tgt[1] <= r_rd[63:32];
                    r_tgt[2] <= r_rd[95:64];
                end
                wrf_pkg::ST_DEC2: begin
                    if (r_dist != '0 && r_step >= r_dist) r_cur <= r_tgt;
                    else if (r_dist != '0) r_go <= 1'b1;
                end
                wrf_pkg::ST_DIV: r_ax <= '0;
                wrf_pkg::ST_LERP: begin
                    r_cur[r_ax] <= r_neg[r_ax] ? r_base[r_ax] - w_off[31:0]
                                               : r_base[r_ax] + w_off[31:0];
                    r_ax <= r_ax + 2'd1;
                end
                wrf_pkg::ST_OUT: if (!r_ovalid) begin
                    r_ovalid <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    // result beat: ST_OUT raises valid then returns to idle
    assign o_valid          = r_ovalid;
    assign o_pos_x          = r_cur[0];
    assign o_pos_y          = r_cur[1];
    assign o_pos_z          = r_cur[2];
    assign o_arrived        = r_arr;
    assign o_active         = r_moving;
    assign o_route_overflow = r_ovf;

    `WRF_ASSERT(a_cnt_range, r_count <= DEPTH_C, "route count beyond depth")
    `WRF_ASSERT(a_busy_stall, !r_ovalid || o_stall, "input open while result waits")
    `WRF_ASSERT_NEXT(a_hold, r_ovalid && i_stall, r_ovalid && $stable(o_pos_x), "result moved")
    `WRF_ASSERT_NEXT(a_arr_stop, r_ovalid && r_arr, !r_moving, "arrived while moving")
    `WRF_ASSERT(a_unit_idle, !(w_busy && r_state == wrf_pkg::ST_IDLE), "unit busy in idle")
endmodule
